FILE: rtl/getsc_pkg.sv
// ----------------------------------------------------------------------------
// getsc_pkg
// Shared types and constants for the global EDF tick scheduler.
// ----------------------------------------------------------------------------
package getsc_pkg;

	localparam int NTASK = 16;
	localparam int IDXW  = 4;
	localparam int LENW  = 5;
	localparam int MPROC = 8;
	localparam int MW    = 4;
	localparam int TW    = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SEL,
		ST_REL,
		ST_INS,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic tick_start;
		logic mod_step;
		logic mod_skip;
		logic sel_step;
		logic release_job;
		logic ins_step;
		logic ins_do;
		logic run_step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic elig;
		logic bit_zero;
		logic tk_last;
		logic best_valid;
		logic ins_more;
		logic run_more;
	} sts_t;

endpackage

FILE: rtl/global_edf_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// global_edf_tick_scheduler_core
// Global preemptive EDF scheduler for periodic tasks, one result per item.
// ----------------------------------------------------------------------------
// A load item or a tick holds the input until it is through. A tick first checks every
// enabled task with a non-zero period that is not queued (a shared bit-serial
// remainder unit checks one time bit a cycle whether its period divides the time),
// then makes one pick pass over all entries and one ordered insertion for each job
// released, and ends with a run walk over the queued jobs. The result register lets
// the next item be taken while one waits.
module global_edf_tick_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // task_index, task_period, task_exec_time, task_enable
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // running_mask, finished_mask, missed_mask,
	                              // tick_preemptions, total_preemptions
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data  // processor_count
);

	getsc_pkg::cmd_t cmd;
	getsc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	getsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	getsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.in_index  (s_tdata[3:0]),
		.in_period (s_tdata[19:4]),
		.in_exec   (s_tdata[35:20]),
		.in_enable (s_tdata[36]),
		.res       (m_tdata)
	);

endmodule

FILE: rtl/getsc_ctrl.sv
// ----------------------------------------------------------------------------
// getsc_ctrl
// Sequencer: takes load items and walks the period check, pick, release, insertion and run phases of each tick.
// ----------------------------------------------------------------------------
module getsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             op,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  getsc_pkg::sts_t  sts,
	output getsc_pkg::cmd_t  cmd
);

	getsc_pkg::state_t state_q, state_nx;
	logic              mvalid_q;
	logic              acc;

	assign s_tready = (state_q == getsc_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = mvalid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			getsc_pkg::ST_IDLE: begin
				if (acc)
					state_nx = (op == getsc_pkg::OP_TICK) ? getsc_pkg::ST_MOD
						: getsc_pkg::ST_DONE;
			end
			getsc_pkg::ST_MOD: begin
				if (sts.tk_last && (!sts.elig || sts.bit_zero))
					state_nx = getsc_pkg::ST_SEL;
			end
			getsc_pkg::ST_SEL: begin
				if (sts.tk_last)
					state_nx = getsc_pkg::ST_REL;
			end
			getsc_pkg::ST_REL: begin
				state_nx = sts.best_valid ? getsc_pkg::ST_INS : getsc_pkg::ST_RUN;
			end
			getsc_pkg::ST_INS: begin
				if (!sts.ins_more)
					state_nx = getsc_pkg::ST_SEL;
			end
			getsc_pkg::ST_RUN: begin
				if (!sts.run_more)
					state_nx = getsc_pkg::ST_DONE;
			end
			getsc_pkg::ST_DONE: begin
				if (!mvalid_q || m_tready)
					state_nx = getsc_pkg::ST_IDLE;
			end
			default: state_nx = getsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			getsc_pkg::ST_IDLE: begin
				cmd.load       = acc && (op == getsc_pkg::OP_LOAD);
				cmd.tick_start = acc && (op == getsc_pkg::OP_TICK);
			end
			getsc_pkg::ST_MOD: begin
				cmd.mod_step = sts.elig;
				cmd.mod_skip = !sts.elig;
			end
			getsc_pkg::ST_SEL: cmd.sel_step = 1'b1;
			getsc_pkg::ST_REL: cmd.release_job = sts.best_valid;
			getsc_pkg::ST_INS: begin
				cmd.ins_step = sts.ins_more;
				cmd.ins_do   = !sts.ins_more;
			end
			getsc_pkg::ST_RUN: begin
				cmd.run_step = sts.run_more;
				cmd.finish   = !sts.run_more;
			end
			getsc_pkg::ST_DONE: cmd.out_load = !mvalid_q || m_tready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= getsc_pkg::ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/getsc_dp.sv
// ----------------------------------------------------------------------------
// getsc_dp
// Task tables, ready queue, serial period check and result register.
// ----------------------------------------------------------------------------
module getsc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  getsc_pkg::cmd_t               cmd,
	output getsc_pkg::sts_t               sts,
	input  logic                          cfg_we,
	input  logic [getsc_pkg::MW-1:0]      cfg_data,
	input  logic [getsc_pkg::IDXW-1:0]    in_index,
	input  logic [15:0]                   in_period,
	input  logic [15:0]                   in_exec,
	input  logic                          in_enable,
	output logic [87:0]                   res
);

	logic [15:0]                 period_q [getsc_pkg::NTASK];
	logic [15:0]                 exec_q   [getsc_pkg::NTASK];
	logic [15:0]                 rem_q    [getsc_pkg::NTASK];
	logic [getsc_pkg::TW-1:0]    dl_q     [getsc_pkg::NTASK];
	logic [getsc_pkg::IDXW-1:0]  ord_q    [getsc_pkg::NTASK];
	logic [getsc_pkg::NTASK-1:0] en_q, ex_q, qmask_q, cand_q;
	logic [getsc_pkg::LENW-1:0]  len_q, pos_q, p_q, w_q;
	logic [getsc_pkg::TW-1:0]    time_q, tot_q, dlk_q;
	logic [getsc_pkg::MW-1:0]    mcfg_q;
	logic [getsc_pkg::IDXW-1:0]  tk_q, best_q;
	logic                        bestv_q;
	logic [4:0]                  bit_q;
	logic [15:0]                 mrem_q;
	logic [getsc_pkg::NTASK-1:0] run_q, fin_q, miss_q;
	logic [4:0]                  pre_q;

	logic [getsc_pkg::MW-1:0]    m_eff;
	logic [16:0]                 sh;
	logic [15:0]                 mnext;
	logic [getsc_pkg::LENW-1:0]  cnt;
	logic [getsc_pkg::IDXW-1:0]  ord_p, ord_pos;
	logic [15:0]                 nrem;
	logic [getsc_pkg::TW:0]      tsum;

	always_comb begin
		if (mcfg_q == '0)
			m_eff = getsc_pkg::MW'(1);
		else if (mcfg_q > getsc_pkg::MW'(getsc_pkg::MPROC))
			m_eff = getsc_pkg::MW'(getsc_pkg::MPROC);
		else
			m_eff = mcfg_q;
	end

	// one restoring step of time mod period
	assign sh    = {mrem_q, time_q[bit_q]};
	assign mnext = (sh >= {1'b0, period_q[tk_q]}) ? 16'(sh - {1'b0, period_q[tk_q]})
		: sh[15:0];

	always_comb begin
		cnt = '0;
		for (int i = 0; i < getsc_pkg::NTASK; i++)
			cnt = cnt + getsc_pkg::LENW'(ex_q[i] & qmask_q[i]);
	end

	assign ord_p   = ord_q[p_q[getsc_pkg::IDXW-1:0]];
	assign ord_pos = ord_q[pos_q[getsc_pkg::IDXW-1:0]];
	assign nrem    = rem_q[ord_p] - 16'd1;
	assign tsum    = {1'b0, tot_q} + (getsc_pkg::TW+1)'(pre_q);

	assign sts.elig       = en_q[tk_q] && (period_q[tk_q] != '0) && !qmask_q[tk_q];
	assign sts.bit_zero   = (bit_q == '0);
	assign sts.tk_last    = (tk_q == getsc_pkg::IDXW'(getsc_pkg::NTASK - 1));
	assign sts.best_valid = bestv_q;
	assign sts.ins_more   = (pos_q < len_q) && (dl_q[ord_pos] <= dlk_q);
	assign sts.run_more   = (p_q < len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcfg_q  <= getsc_pkg::MW'(1);
			en_q    <= '0;
			ex_q    <= '0;
			qmask_q <= '0;
			cand_q  <= '0;
			len_q   <= '0;
			time_q  <= '0;
			tot_q   <= '0;
			bestv_q <= 1'b0;
			tk_q    <= '0;
			bit_q   <= '1;
			mrem_q  <= '0;
			pos_q   <= '0;
			p_q     <= '0;
			w_q     <= '0;
			pre_q   <= '0;
			run_q   <= '0;
			fin_q   <= '0;
			miss_q  <= '0;
			for (int i = 0; i < getsc_pkg::NTASK; i++) begin
				rem_q[i] <= '0;
				dl_q[i]  <= '0;
			end
		end else begin
			if (cfg_we)
				mcfg_q <= cfg_data;
			if (cmd.load) begin
				period_q[in_index] <= in_period;
				exec_q[in_index]   <= in_exec;
				en_q[in_index]     <= in_enable;
				run_q  <= '0;
				fin_q  <= '0;
				miss_q <= '0;
				pre_q  <= '0;
			end
			if (cmd.tick_start) begin
				cand_q  <= '0;
				tk_q    <= '0;
				bit_q   <= '1;
				mrem_q  <= '0;
				bestv_q <= 1'b0;
				run_q   <= '0;
				fin_q   <= '0;
				miss_q  <= '0;
				pre_q   <= '0;
			end
			if (cmd.mod_skip)
				tk_q <= tk_q + 1'b1;
			if (cmd.mod_step) begin
				if (bit_q == '0) begin
					cand_q[tk_q] <= (mnext == '0);
					tk_q   <= tk_q + 1'b1;
					bit_q  <= '1;
					mrem_q <= '0;
				end else begin
					bit_q  <= bit_q - 1'b1;
					mrem_q <= mnext;
				end
			end
			// ties keep the lower index
			if (cmd.sel_step) begin
				if (cand_q[tk_q] && (!bestv_q || period_q[tk_q] < period_q[best_q])) begin
					best_q  <= tk_q;
					bestv_q <= 1'b1;
				end
				tk_q <= tk_q + 1'b1;
			end
			if (cmd.release_job) begin
				rem_q[best_q]  <= exec_q[best_q];
				dl_q[best_q]   <= time_q + getsc_pkg::TW'(period_q[best_q]);
				dlk_q          <= time_q + getsc_pkg::TW'(period_q[best_q]);
				ex_q[best_q]   <= 1'b0;
				cand_q[best_q] <= 1'b0;
				bestv_q        <= 1'b0;
				pos_q          <= '0;
			end
			if (cmd.ins_step)
				pos_q <= pos_q + 1'b1;
			if (cmd.ins_do) begin
				qmask_q[best_q] <= 1'b1;
				len_q           <= len_q + 1'b1;
				if (len_q == '0) begin
					ord_q[0] <= best_q;
				end else begin
					for (int i = 1; i < getsc_pkg::NTASK; i++)
						if (getsc_pkg::LENW'(i) > pos_q)
							ord_q[i] <= ord_q[i-1];
					ord_q[pos_q[getsc_pkg::IDXW-1:0]] <= best_q;
					if (pos_q < getsc_pkg::LENW'(m_eff)) begin
						ex_q[best_q] <= 1'b1;
						if (cnt >= getsc_pkg::LENW'(m_eff))
							pre_q <= (pre_q == '1) ? pre_q : pre_q + 1'b1;
					end
				end
				p_q <= '0;
				w_q <= '0;
			end
			if (cmd.release_job == 1'b0 && cmd.sel_step == 1'b0 && cmd.ins_do == 1'b0
				&& cmd.ins_step == 1'b0 && cmd.run_step == 1'b0 && cmd.finish == 1'b0
				&& bestv_q == 1'b0 && tk_q == '0 && cmd.mod_step == 1'b0
				&& cmd.mod_skip == 1'b0 && cmd.tick_start == 1'b0) begin
				p_q <= '0;
				w_q <= '0;
			end
			// run walk with in-place compaction of the queue
			if (cmd.run_step) begin
				p_q <= p_q + 1'b1;
				if (p_q < getsc_pkg::LENW'(m_eff)) begin
					rem_q[ord_p] <= nrem;
					ex_q[ord_p]  <= 1'b1;
					run_q[ord_p] <= 1'b1;
					if (nrem == '0) begin
						fin_q[ord_p]   <= 1'b1;
						miss_q[ord_p]  <= (dl_q[ord_p] <= time_q);
						qmask_q[ord_p] <= 1'b0;
					end else begin
						ord_q[w_q[getsc_pkg::IDXW-1:0]] <= ord_p;
						w_q <= w_q + 1'b1;
					end
				end else begin
					ex_q[ord_p] <= 1'b0;
					ord_q[w_q[getsc_pkg::IDXW-1:0]] <= ord_p;
					w_q <= w_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				len_q  <= w_q;
				time_q <= time_q + 1'b1;
				tot_q  <= tsum[getsc_pkg::TW] ? '1 : tsum[getsc_pkg::TW-1:0];
			end
			if (cmd.out_load)
				res <= {3'b000, tot_q, pre_q, miss_q, fin_q, run_q};
		end
	end

endmodule

FILE: rtl/getsc_chk.sv
// ----------------------------------------------------------------------------
// getsc_chk
// Port-level checks for the scheduler core.
// ----------------------------------------------------------------------------
module getsc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with the core idle nothing new can be loaded behind a taken result
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && s_tready |=> !m_tvalid)
		else $error("result repeated");

	a_pre_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[52:48] <= 5'd16)
		else $error("tick preemptions out of range");

endmodule

bind global_edf_tick_scheduler_core getsc_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_global_edf_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_global_edf_tick_scheduler_core
// Self-checking bench for the EDF tick scheduler. It drives task loads and
// ticks over the stream port, and steps the processor count through several
// settings. Every result transaction is compared against a local EDF
// scheduling predictor, or against a typed result from the directed table.
// ----------------------------------------------------------------------------
module tb_global_edf_tick_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 2000;
	localparam int N_RAND = 730;

	typedef struct packed {
		logic        op;
		logic [3:0]  idx;
		logic [15:0] per;
		logic [15:0] ex;
		logic        en;
	} sched_item_t;

	// highest field first, so running_mask sits in the lowest bits
	typedef struct packed {
		logic [31:0] total;
		logic [4:0]  tpre;
		logic [15:0] miss;
		logic [15:0] fin;
		logic [15:0] run;
	} sched_res_t;

	typedef struct packed {
		sched_item_t it;
		logic        chk;
		sched_res_t  res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // task_index, task_period, task_exec_time, task_enable
	logic        s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;   // running_mask, finished_mask, missed_mask,
	                        // tick_preemptions, total_preemptions
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;  // processor_count

	// predictor state
	logic [31:0] cur_time;
	logic [15:0] per_tab [getsc_pkg::NTASK];
	logic [15:0] exe_tab [getsc_pkg::NTASK];
	logic        en_f [getsc_pkg::NTASK];
	logic [3:0]  order [getsc_pkg::NTASK];
	int          qlen;
	logic [15:0] rem [getsc_pkg::NTASK];
	logic [31:0] dl [getsc_pkg::NTASK];
	logic        exf [getsc_pkg::NTASK];
	logic [31:0] pre_total;
	logic [3:0]  nprocs;

	sched_res_t sched_expect_q[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  hold_req = 1'b0;

	global_edf_tick_scheduler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit queued(int k);
		for (int p = 0; p < qlen; p++)
			if (order[p] == k) return 1'b1;
		return 1'b0;
	endfunction

	// deadline-ordered insert, after equal deadlines; returns preemption count
	function automatic int ready_insert(int k, int m);
		int pos;
		int cnt;
		pos = 0;
		cnt = 0;
		if (qlen == 0) begin
			order[0] = 4'(k);
			qlen = 1;
			return 0;
		end
		while (pos < qlen && dl[order[pos]] <= dl[k])
			pos++;
		if (pos < m) exf[k] = 1'b1;
		for (int p = 0; p < qlen; p++)
			if (exf[order[p]]) cnt++;
		if (qlen >= getsc_pkg::NTASK) return 0;
		for (int p = qlen; p > pos; p--)
			order[p] = order[p-1];
		order[pos] = 4'(k);
		qlen++;
		return (pos < m && cnt >= m) ? 1 : 0;
	endfunction

	function automatic void ready_remove(int k);
		int q;
		q = 0;
		for (int p = 0; p < qlen; p++)
			if (order[p] != k) begin
				order[q] = order[p];
				q++;
			end
		qlen = q;
	endfunction

	function automatic sched_res_t edf_step(sched_item_t it);
		sched_res_t r;
		int m;
		int n;
		int best;
		int pre;
		int k;
		logic [3:0] front [getsc_pkg::NTASK];
		longint sum;
		r = '0;
		pre = 0;
		if (it.op == getsc_pkg::OP_LOAD) begin
			per_tab[it.idx] = it.per;
			exe_tab[it.idx] = it.ex;
			en_f[it.idx] = it.en;
		end else begin
			m = (nprocs == 0) ? 1
				: ((nprocs > getsc_pkg::MPROC) ? getsc_pkg::MPROC : nprocs);
			while (1) begin
				best = -1;
				for (k = 0; k < getsc_pkg::NTASK; k++) begin
					if (!en_f[k] || per_tab[k] == 0) continue;
					if (cur_time % per_tab[k] != 0 || queued(k)) continue;
					if (best < 0 || per_tab[k] < per_tab[best]) best = k;
				end
				if (best < 0) break;
				rem[best] = exe_tab[best];
				dl[best] = cur_time + per_tab[best];
				exf[best] = 1'b0;
				pre += ready_insert(best, m);
			end
			n = (qlen < m) ? qlen : m;
			for (int p = 0; p < qlen; p++) begin
				k = order[p];
				if (p < n) begin
					rem[k] = rem[k] - 16'd1;
					exf[k] = 1'b1;
					r.run[k] = 1'b1;
				end else
					exf[k] = 1'b0;
			end
			for (int p = 0; p < n; p++)
				front[p] = order[p];
			for (int p = 0; p < n; p++) begin
				k = front[p];
				if (rem[k] == 0) begin
					r.fin[k] = 1'b1;
					if (dl[k] <= cur_time) r.miss[k] = 1'b1;
					ready_remove(k);
				end
			end
			sum = longint'(pre_total) + pre;
			pre_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			r.tpre = (pre > 31) ? 5'd31 : pre[4:0];
			cur_time++;
		end
		r.total = pre_total;
		return r;
	endfunction

	function automatic sched_item_t rand_item();
		sched_item_t it;
		int sel;
		it.op = ($urandom_range(0, 9) < 3) ? getsc_pkg::OP_LOAD : getsc_pkg::OP_TICK;
		it.idx = 4'($urandom_range(0, 15));
		it.en = ($urandom_range(0, 3) != 0);
		if (it.en) begin
			sel = $urandom_range(0, 19);
			if (sel < 17) it.per = 16'($urandom_range(1, 16));
			else if (sel < 19) it.per = 16'($urandom_range(17, 300));
			else it.per = 16'd0;
			it.ex = 16'($urandom_range(1, 5));
		end else begin
			// disabled entries carry wide values; never released
			it.per = 16'($urandom);
			it.ex = 16'($urandom);
		end
		return it;
	endfunction

	// one stream transaction; leaves tvalid high for a following burst item
	task automatic send_item(sched_item_t it, bit chk, sched_res_t typed);
		sched_res_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {3'b0, it.en, it.ex, it.per, it.idx};
		do @(posedge clk); while (!s_tready);
		r = edf_step(it);
		sched_expect_q.push_back(chk ? typed : r);
		@(negedge clk);
	endtask

	task automatic set_procs(logic [3:0] v);
		s_tvalid <= 1'b0;
		wait (sched_expect_q.size() == 0);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		nprocs = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		sched_res_t got;
		sched_res_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[84:0];
				if (sched_expect_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					want = sched_expect_q.pop_front();
					if (got.run !== want.run)
						$display("%0t: running_mask exp %h got %h", $time, want.run, got.run);
					if (got.fin !== want.fin)
						$display("%0t: finished_mask exp %h got %h", $time, want.fin, got.fin);
					if (got.miss !== want.miss)
						$display("%0t: missed_mask exp %h got %h", $time, want.miss, got.miss);
					if (got.tpre !== want.tpre)
						$display("%0t: tick_preemptions exp %0d got %0d", $time, want.tpre,
							got.tpre);
					if (got.total !== want.total)
						$display("%0t: total_preemptions exp %0d got %0d", $time, want.total,
							got.total);
					if (m_tdata[87:85] !== 3'b0)
						$display("%0t: padding exp 000 got %b", $time, m_tdata[87:85]);
					if (got !== want || m_tdata[87:85] !== 3'b0) errors++;
				end
			end
		end
	end

	// receiver: stall patterns picked at random in turn, plus one long hold-off
	initial begin
		int mode;
		int cnt;
		m_tready = 1'b0;
		mode = 0;
		cnt = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (cnt == 0) mode = $urandom_range(0, 3);
				cnt = (cnt + 1) % 64;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (cnt % 4 == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		dir_row_t   dir_tab [$];
		sched_item_t it;
		logic [3:0] phase_m [8];
		int burst;
		int gap;
		int cnt;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = getsc_pkg::OP_LOAD;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cur_time = '0;
		qlen = 0;
		pre_total = '0;
		nprocs = 4'd1;
		for (int k = 0; k < getsc_pkg::NTASK; k++) begin
			per_tab[k] = '0; exe_tab[k] = '0; en_f[k] = 1'b0; order[k] = '0;
			rem[k] = '0; dl[k] = '0; exf[k] = 1'b0;
		end
		phase_m = '{4'd3, 4'd0, 4'd8, 4'd15, 4'd1, 4'd2, 4'd5, 4'd4};

		// op, index, period, exec, enable, typed check, typed result
		dir_tab = '{
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b1, '0},
			'{'{getsc_pkg::OP_LOAD, 4'd0,  16'd0,    16'd3,    1'b1}, 1'b1, '0},  // zero period
			'{'{getsc_pkg::OP_LOAD, 4'd1,  16'd4,    16'd2,    1'b1}, 1'b1, '0},
			'{'{getsc_pkg::OP_LOAD, 4'd2,  16'd4,    16'd1,    1'b1}, 1'b1, '0},  // period tie
			'{'{getsc_pkg::OP_LOAD, 4'd3,  16'd2,    16'd3,    1'b1}, 1'b1, '0},
			'{'{getsc_pkg::OP_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_LOAD, 4'd4,  16'd1,    16'd1,    1'b1}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			// reload while queued
			'{'{getsc_pkg::OP_LOAD, 4'd1,  16'd5,    16'd9,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_LOAD, 4'd5,  16'd300,  16'd1,    1'b1}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0},
			'{'{getsc_pkg::OP_TICK, 4'd0,  16'd0,    16'd0,    1'b0}, 1'b0, '0}
		};

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, back to back under the reset processor count
		foreach (dir_tab[i])
			send_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].res);

		burst = 0;
		cnt = 0;
		for (int ph = 0; ph < 8; ph++) begin
			set_procs(phase_m[ph]);
			if (ph == 1) hold_req = 1'b1;
			// zero exec time: remaining time wraps, job occupies a processor
			if (ph == 6) begin
				it = '{getsc_pkg::OP_LOAD, 4'd14, 16'd3, 16'd0, 1'b1};
				send_item(it, 1'b0, '0);
			end
			for (int i = 0; i < N_RAND / 8; i++) begin
				if (ph == 2 && i == 40) begin
					s_tvalid <= 1'b0;
					wait (sched_expect_q.size() == 0);
					@(negedge clk);
				end else if (burst <= 0) begin
					burst = $urandom_range(1, 20);
					gap = (cnt % 3 == 0) ? 0 : $urandom_range(1, 60);
					cnt++;
					if (gap > 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end
				burst--;
				send_item(rand_item(), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		wait (sched_expect_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
